// ===== rtl/qmsa_pkg.sv =====
// Package with the payload types, widths and control structs of the quaternion mean block.
`timescale 1ns / 1ps
`default_nettype none
package qmsa_pkg;

  localparam int NUM_COMP    = 4;
  localparam int COMP_W      = 16;
  localparam int SUM_W       = 23;
  localparam int PROD_W      = 2 * SUM_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int NORM_W      = PROD_W + 1;
  localparam int Q_W         = 16;
  localparam int QN_W        = NORM_W + Q_W + 1;
  localparam int ROOT_W      = 80;
  localparam int SCALE_SHIFT = 30;
  localparam int IDX_W       = $clog2(NUM_COMP);
  localparam int BIT_W       = $clog2(Q_W);

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic signed [COMP_W-1:0] OUT_MAX = {1'b0, {(COMP_W-1){1'b1}}};

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic signed [COMP_W-1:0] quat_w;
    logic                     last_sample;
  } sample_t;

  typedef struct packed {
    logic signed [COMP_W-1:0] mean_x;
    logic signed [COMP_W-1:0] mean_y;
    logic signed [COMP_W-1:0] mean_z;
    logic signed [COMP_W-1:0] mean_w;
  } mean_t;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    logic             mul_sq;
    logic [IDX_W-1:0] mul_idx;
    logic             acc_clr;
    logic             acc_en;
    logic             update;
    logic             root_init;
    logic             root_prep;
    logic             root_step;
    logic [BIT_W-1:0] bit_idx;
    logic [IDX_W-1:0] comp;
    logic             store;
    logic             out_load;
  } qmsa_cmd_t;

  typedef struct packed {
    logic last;
    logic out_free;
  } qmsa_status_t;

endpackage
`default_nettype wire

// ===== rtl/qmsa_datapath.sv =====
// Datapath: sample register, component sums, shared multiplier, accumulator and root unit.
`timescale 1ns / 1ps
`default_nettype none
module qmsa_datapath
  import qmsa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire sample_t      sample,
  input  wire qmsa_cmd_t    cmd,
  output qmsa_status_t      status,
  output logic              mean_valid,
  input  wire logic         mean_stall,
  output mean_t             mean
);

  localparam int EXT_W = SUM_W + 2;

  sample_t                   cur;
  logic signed [SUM_W-1:0]   sums [NUM_COMP];
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic [ROOT_W-1:0]         rem;
  logic [ROOT_W-1:0]         dsub;
  logic [QN_W-1:0]           qn;
  logic [Q_W-1:0]            q;
  logic signed [COMP_W-1:0]  res [NUM_COMP];

  logic signed [SUM_W-1:0]   mul_a;
  logic signed [SUM_W-1:0]   mul_b;
  logic [NORM_W-1:0]         norm;
  logic                      dot_neg;
  logic signed [SUM_W-1:0]   store_sum;
  logic signed [COMP_W-1:0]  store_val;

  function automatic logic signed [COMP_W-1:0] comp_sel(sample_t s, logic [IDX_W-1:0] i);
    logic signed [COMP_W-1:0] v;
    case (i)
      2'd0:    v = s.quat_x;
      2'd1:    v = s.quat_y;
      2'd2:    v = s.quat_z;
      default: v = s.quat_w;
    endcase
    return v;
  endfunction

  assign norm    = acc[NORM_W-1:0];
  assign dot_neg = acc[ACC_W-1];

  assign mul_b = sums[cmd.mul_idx];
  assign mul_a = cmd.mul_sq ? sums[cmd.mul_idx] : SUM_W'(comp_sel(cur, cmd.mul_idx));

  // Result of one component: magnitude from the root unit, sign from the sum.
  assign store_sum = sums[cmd.comp];
  always_comb begin
    if (norm == '0 || store_sum == '0) begin
      store_val = '0;
    end else if (!store_sum[SUM_W-1]) begin
      store_val = q[Q_W-1] ? OUT_MAX : COMP_W'(q);
    end else begin
      store_val = COMP_W'((Q_W + 1)'(0) - {1'b0, q});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= sample;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
    // Root search: largest q with q*q*norm <= sum*sum*2^30, one bit per prep and step pair.
    if (cmd.root_init) begin
      rem <= ROOT_W'(prod[PROD_W-2:0]) << SCALE_SHIFT;
      qn  <= '0;
      q   <= '0;
    end
    if (cmd.root_prep) begin
      dsub <= (ROOT_W'(qn) << ({1'b0, cmd.bit_idx} + 5'd1))
            + (ROOT_W'(norm) << {cmd.bit_idx, 1'b0});
    end
    if (cmd.root_step && dsub <= rem) begin
      rem        <= rem - dsub;
      qn         <= qn + (QN_W'(norm) << cmd.bit_idx);
      q[cmd.bit_idx] <= 1'b1;
    end
    if (cmd.store) begin
      res[cmd.comp] <= store_val;
    end
    if (cmd.out_load) begin
      mean.mean_x <= res[0];
      mean.mean_y <= res[1];
      mean.mean_z <= res[2];
      mean.mean_w <= res[3];
    end
  end

  // Component sums: sign-aligned saturating update, cleared after a result is formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        sums[i] <= '0;
      end
    end else if (cmd.out_load) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        sums[i] <= '0;
      end
    end else if (cmd.update) begin
      for (int i = 0; i < NUM_COMP; i++) begin
        logic signed [EXT_W-1:0] ext;
        logic signed [EXT_W-1:0] cv;
        logic signed [EXT_W-1:0] nv;
        ext = EXT_W'(sums[i]);
        cv  = EXT_W'(comp_sel(cur, IDX_W'(i)));
        nv  = dot_neg ? ext - cv : ext + cv;
        if (nv > EXT_W'(SUM_MAX)) begin
          sums[i] <= SUM_MAX;
        end else if (nv < EXT_W'(SUM_MIN)) begin
          sums[i] <= SUM_MIN;
        end else begin
          sums[i] <= SUM_W'(nv);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_valid <= 1'b0;
    end else if (cmd.out_load) begin
      mean_valid <= 1'b1;
    end else if (!mean_stall) begin
      mean_valid <= 1'b0;
    end
  end

  assign status.last     = cur.last_sample;
  assign status.out_free = !mean_valid || !mean_stall;

endmodule
`default_nettype wire

// ===== rtl/qmsa_ctrl.sv =====
// Controller: sequences the dot product, sum update, norm and per-component root search.
`timescale 1ns / 1ps
`default_nettype none
module qmsa_ctrl
  import qmsa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         sample_valid,
  output logic              sample_stall,
  input  wire qmsa_status_t status,
  output qmsa_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_UPDATE, S_NORM, S_SQ, S_RINIT, S_PREP, S_STEP, S_STORE, S_OUT
  } state_t;

  localparam int CNT_W = $clog2(NUM_COMP + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_COMP);
  localparam logic [IDX_W-1:0] COMP_LAST = IDX_W'(NUM_COMP - 1);
  localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(Q_W - 1);

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic [BIT_W-1:0] bit_idx;
  logic [IDX_W-1:0] comp;
  logic             busy;

  assign sample_stall = busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      bit_idx <= '0;
      comp    <= '0;
      busy    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_DOT;
            cnt   <= '0;
            busy  <= 1'b1;
          end
        end
        S_DOT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (status.last) begin
            state <= S_NORM;
            cnt   <= '0;
          end else begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        S_NORM: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= S_SQ;
            comp  <= '0;
          end
        end
        S_SQ: begin
          state <= S_RINIT;
        end
        S_RINIT: begin
          state   <= S_PREP;
          bit_idx <= BIT_TOP;
        end
        S_PREP: begin
          state <= S_STEP;
        end
        S_STEP: begin
          if (bit_idx == '0) begin
            state <= S_STORE;
          end else begin
            bit_idx <= bit_idx - 1'b1;
            state   <= S_PREP;
          end
        end
        S_STORE: begin
          if (comp == COMP_LAST) begin
            state <= S_OUT;
          end else begin
            comp  <= comp + 1'b1;
            state <= S_SQ;
          end
        end
        S_OUT: begin
          if (status.out_free) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    logic mac_phase;
    mac_phase     = (state == S_DOT) || (state == S_NORM);
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && sample_valid && !busy;
    cmd.mul_en    = (mac_phase && cnt != CNT_LAST) || (state == S_SQ);
    cmd.mul_sq    = (state != S_DOT);
    cmd.mul_idx   = (state == S_SQ) ? comp : cnt[IDX_W-1:0];
    cmd.acc_clr   = cmd.load || ((state == S_UPDATE) && status.last);
    cmd.acc_en    = mac_phase && cnt != '0;
    cmd.update    = (state == S_UPDATE);
    cmd.root_init = (state == S_RINIT);
    cmd.root_prep = (state == S_PREP);
    cmd.root_step = (state == S_STEP);
    cmd.bit_idx   = bit_idx;
    cmd.comp      = comp;
    cmd.store     = (state == S_STORE);
    cmd.out_load  = (state == S_OUT) && status.out_free;
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_mean_sign_aligned.sv =====
// Top level of the sign-aligned quaternion mean: controller, datapath and checks.
//
// Usage: quaternions in Q1.15 arrive one per request on the sample channel
// (sample_valid, sample_stall, sample); the request flagged last_sample closes
// the batch. Each quaternion is negated when its dot product with the running
// sums is negative, then added to the saturating 23-bit sums. The closing
// request yields one result on the mean channel (mean_valid, mean_stall, mean):
// the sum scaled to unit length in Q1.15, truncated toward zero, all zero for a
// zero sum. The sums clear once the result is loaded.
// A request that does not close a batch keeps the channel stalled while the
// shared multiplier does four products in turn and the sums are updated.
// A closing request goes on to form the norm from four squares, and per component
// runs a 16-bit root search, one bit per prepare and step pair, to form the result.
// The result sits in an output register; while the receiver stalls, the next
// batch is accepted and only a second result waits for the register to drain.
// Reset (synchronous, rst high) clears the sums and the handshakes at once.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_mean_sign_aligned
  import qmsa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    sample_valid,
  output logic         sample_stall,
  input  wire sample_t sample,
  output logic         mean_valid,
  input  wire logic    mean_stall,
  output mean_t        mean
);

  qmsa_cmd_t    cmd;
  qmsa_status_t status;

  qmsa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  qmsa_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .sample     (sample),
    .cmd        (cmd),
    .status     (status),
    .mean_valid (mean_valid),
    .mean_stall (mean_stall),
    .mean       (mean)
  );

  // The datapath takes a request exactly when the channel accepts one.
  a_load_matches_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.load == (sample_valid && !sample_stall))
    else $error("sample load does not match channel accept");

  // A pending result is never overwritten.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!mean_valid || !mean_stall))
    else $error("result loaded over a stalled result");

  // A loaded result is offered in the next cycle.
  a_result_offered: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> mean_valid)
    else $error("loaded result not offered");

  // No new request is taken while the batch end is being worked out.
  a_busy_during_root: assert property (@(posedge clk) disable iff (rst)
    (cmd.root_prep || cmd.root_step || cmd.store) |-> sample_stall)
    else $error("request accepted during normalization");

endmodule
`default_nettype wire
